### hw/rtl/gast_pkg.sv
// ----------------------------------------------------------------------------
// gast_pkg
// Shared constants, command codes and status type for the grid A* next-step
// finder.
// ----------------------------------------------------------------------------
package gast_pkg;

  localparam int MAP_DIM          = 64;
  localparam int NEIGHBOURS       = 8;
  localparam int RADIUS_DEF       = 12;
  localparam int WINDOW_CELLS_DEF = 625;
  localparam int CFG_W            = 7;

  localparam logic REG_MAP_WIDTH  = 1'b0;
  localparam logic REG_MAP_HEIGHT = 1'b1;

  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NONE     = 5'd0;
  localparam logic [OP_W-1:0] OP_CAPTURE  = 5'd1;
  localparam logic [OP_W-1:0] OP_MAP_RD   = 5'd2;
  localparam logic [OP_W-1:0] OP_MAP_WR   = 5'd3;
  localparam logic [OP_W-1:0] OP_CLR      = 5'd4;
  localparam logic [OP_W-1:0] OP_INIT     = 5'd5;
  localparam logic [OP_W-1:0] OP_POP      = 5'd6;
  localparam logic [OP_W-1:0] OP_POP_W    = 5'd7;
  localparam logic [OP_W-1:0] OP_NODE_W   = 5'd8;
  localparam logic [OP_W-1:0] OP_NB_RD    = 5'd9;
  localparam logic [OP_W-1:0] OP_NB_CHK   = 5'd10;
  localparam logic [OP_W-1:0] OP_CHAIN_RD = 5'd11;
  localparam logic [OP_W-1:0] OP_CHAIN_CK = 5'd12;
  localparam logic [OP_W-1:0] OP_ADD      = 5'd13;
  localparam logic [OP_W-1:0] OP_INS      = 5'd14;
  localparam logic [OP_W-1:0] OP_INS_HEAD = 5'd15;
  localparam logic [OP_W-1:0] OP_NB_NEXT  = 5'd16;
  localparam logic [OP_W-1:0] OP_TRACE    = 5'd17;
  localparam logic [OP_W-1:0] OP_TRACE_W  = 5'd18;
  localparam logic [OP_W-1:0] OP_FAIL     = 5'd19;
  localparam logic [OP_W-1:0] OP_LOAD     = 5'd20;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } gast_cmd_t;

  typedef struct packed {
    logic is_find;
    logic clr_last;
    logic pop_stop;
    logic at_goal;
    logic nb_pass;
    logic chain_hit;
    logic chain_root;
    logic ins_direct;
    logic ins_shift;
    logic ins_first;
    logic k_last;
    logic cur_has_par;
    logic trace_root;
    logic out_free;
  } gast_stat_t;

  // neighbour order: N, W, E, S, NE, NW, SW, SE
  function automatic logic signed [1:0] dir_dx(input logic [2:0] k);
    logic signed [1:0] r;
    case (k)
      3'd0: r = 2'sd0;
      3'd1: r = -2'sd1;
      3'd2: r = 2'sd1;
      3'd3: r = 2'sd0;
      3'd4: r = 2'sd1;
      3'd5: r = -2'sd1;
      3'd6: r = -2'sd1;
      default: r = 2'sd1;
    endcase
    return r;
  endfunction

  function automatic logic signed [1:0] dir_dy(input logic [2:0] k);
    logic signed [1:0] r;
    case (k)
      3'd0: r = -2'sd1;
      3'd1: r = 2'sd0;
      3'd2: r = 2'sd0;
      3'd3: r = 2'sd1;
      3'd4: r = -2'sd1;
      3'd5: r = -2'sd1;
      3'd6: r = 2'sd1;
      default: r = 2'sd1;
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/grid_astar_next_step.sv
// ----------------------------------------------------------------------------
// grid_astar_next_step
// 8-neighbour A* on a loaded walkability map; returns the first step of the
// path from source to goal.
//
//   channel  signals                       direction
//   in       in_valid / in_stall + fields  item in (map write or find)
//   out      out_valid / out_stall + found result out (one per find)
//   cfg      cfg_write, cfg_index, cfg_data map width / height
//
// A map write reads the row and writes it back. A find clears the best-cost
// store entry by entry, seeds the open list, then per expansion pops a node
// and tests each neighbour against the map, window and cost; one that passes
// walks the chain of ancestors, and one that is queued is inserted by
// shifting open-list entries. Tracing back walks the parents one step at a
// time. The node pool and open list set the pace. One item at a time.
// Reset is synchronous and clears the map to blocked. The result waits in
// its register under out_stall; map writes carry on behind it.
// ----------------------------------------------------------------------------
module grid_astar_next_step import gast_pkg::*; #(
  parameter int RADIUS       = RADIUS_DEF,
  parameter int WINDOW_CELLS = WINDOW_CELLS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             operation,
  input  logic [5:0]       cell_x,
  input  logic [5:0]       cell_y,
  input  logic             cell_walkable,
  input  logic [5:0]       start_x,
  input  logic [5:0]       start_y,
  input  logic [5:0]       goal_x,
  input  logic [5:0]       goal_y,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             found,
  output logic [5:0]       step_x,
  output logic [5:0]       step_y
);

  gast_cmd_t  cmd;
  gast_stat_t stat;

  gast_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  gast_dp #(
    .RADIUS       (RADIUS),
    .WINDOW_CELLS (WINDOW_CELLS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .operation     (operation),
    .cell_x        (cell_x),
    .cell_y        (cell_y),
    .cell_walkable (cell_walkable),
    .start_x       (start_x),
    .start_y       (start_y),
    .goal_x        (goal_x),
    .goal_y        (goal_y),
    .cmd           (cmd),
    .stat          (stat),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .found         (found),
    .step_x        (step_x),
    .step_y        (step_y)
  );

endmodule

### hw/rtl/gast_ctrl.sv
// ----------------------------------------------------------------------------
// gast_ctrl
// Sequencer for map writes and the A* search; issues one command per cycle.
// ----------------------------------------------------------------------------
module gast_ctrl import gast_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output gast_cmd_t  cmd,
  input  gast_stat_t stat
);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_DISPATCH = 5'd1;
  localparam logic [4:0] S_MAP_RD   = 5'd2;
  localparam logic [4:0] S_MAP_WR   = 5'd3;
  localparam logic [4:0] S_CLR      = 5'd4;
  localparam logic [4:0] S_INIT     = 5'd5;
  localparam logic [4:0] S_POP      = 5'd6;
  localparam logic [4:0] S_POP_W    = 5'd7;
  localparam logic [4:0] S_NODE_W   = 5'd8;
  localparam logic [4:0] S_NODE_CHK = 5'd9;
  localparam logic [4:0] S_NB_RD    = 5'd10;
  localparam logic [4:0] S_NB_CHK   = 5'd11;
  localparam logic [4:0] S_CHAIN_RD = 5'd12;
  localparam logic [4:0] S_CHAIN_CK = 5'd13;
  localparam logic [4:0] S_ADD      = 5'd14;
  localparam logic [4:0] S_INS      = 5'd15;
  localparam logic [4:0] S_INS_HEAD = 5'd16;
  localparam logic [4:0] S_NB_NEXT  = 5'd17;
  localparam logic [4:0] S_TRACE    = 5'd18;
  localparam logic [4:0] S_TRACE_W  = 5'd19;
  localparam logic [4:0] S_FAIL     = 5'd20;
  localparam logic [4:0] S_DONE     = 5'd21;

  logic [4:0] state, state_next;

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_CAPTURE;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: state_next = stat.is_find ? S_CLR : S_MAP_RD;
      S_MAP_RD: begin
        cmd.op     = OP_MAP_RD;
        state_next = S_MAP_WR;
      end
      S_MAP_WR: begin
        cmd.op     = OP_MAP_WR;
        state_next = S_IDLE;
      end
      S_CLR: begin
        cmd.op = OP_CLR;
        if (stat.clr_last) state_next = S_INIT;
      end
      S_INIT: begin
        cmd.op     = OP_INIT;
        state_next = S_POP;
      end
      S_POP: begin
        cmd.op     = OP_POP;
        state_next = stat.pop_stop ? S_FAIL : S_POP_W;
      end
      S_POP_W: begin
        cmd.op     = OP_POP_W;
        state_next = S_NODE_W;
      end
      S_NODE_W: begin
        cmd.op     = OP_NODE_W;
        state_next = S_NODE_CHK;
      end
      S_NODE_CHK: state_next = stat.at_goal ? S_TRACE : S_NB_RD;
      S_NB_RD: begin
        cmd.op     = OP_NB_RD;
        state_next = S_NB_CHK;
      end
      S_NB_CHK: begin
        cmd.op     = OP_NB_CHK;
        state_next = stat.nb_pass ? S_CHAIN_RD : S_NB_NEXT;
      end
      S_CHAIN_RD: begin
        cmd.op     = OP_CHAIN_RD;
        state_next = S_CHAIN_CK;
      end
      S_CHAIN_CK: begin
        cmd.op = OP_CHAIN_CK;
        if (stat.chain_hit)       state_next = S_NB_NEXT;
        else if (stat.chain_root) state_next = S_ADD;
        else                      state_next = S_CHAIN_RD;
      end
      S_ADD: begin
        cmd.op     = OP_ADD;
        state_next = stat.ins_direct ? S_NB_NEXT : S_INS;
      end
      S_INS: begin
        cmd.op = OP_INS;
        if (!stat.ins_shift)     state_next = S_NB_NEXT;
        else if (stat.ins_first) state_next = S_INS_HEAD;
      end
      S_INS_HEAD: begin
        cmd.op     = OP_INS_HEAD;
        state_next = S_NB_NEXT;
      end
      S_NB_NEXT: begin
        cmd.op     = OP_NB_NEXT;
        state_next = stat.k_last ? S_POP : S_NB_RD;
      end
      S_TRACE: begin
        cmd.op     = OP_TRACE;
        state_next = stat.cur_has_par ? S_TRACE_W : S_FAIL;
      end
      S_TRACE_W: begin
        cmd.op = OP_TRACE_W;
        if (stat.trace_root) state_next = S_DONE;
      end
      S_FAIL: begin
        cmd.op     = OP_FAIL;
        state_next = S_DONE;
      end
      S_DONE: begin
        cmd.op = OP_LOAD;
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### hw/rtl/gast_dp.sv
// ----------------------------------------------------------------------------
// gast_dp
// Datapath: walk map, best-cost store, node pool, sorted open list and the
// result register.
// ----------------------------------------------------------------------------
module gast_dp import gast_pkg::*; #(
  parameter int RADIUS       = RADIUS_DEF,
  parameter int WINDOW_CELLS = WINDOW_CELLS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             operation,
  input  logic [5:0]       cell_x,
  input  logic [5:0]       cell_y,
  input  logic             cell_walkable,
  input  logic [5:0]       start_x,
  input  logic [5:0]       start_y,
  input  logic [5:0]       goal_x,
  input  logic [5:0]       goal_y,
  input  gast_cmd_t        cmd,
  output gast_stat_t       stat,
  input  logic             out_stall,
  output logic             out_valid,
  output logic             found,
  output logic [5:0]       step_x,
  output logic [5:0]       step_y
);

  localparam int SPAN = 2 * RADIUS + 1;
  localparam int POOL = WINDOW_CELLS * NEIGHBOURS + 1;
  localparam int NW   = $clog2(POOL);
  localparam int OCW  = $clog2(POOL + 1);
  localparam int CW   = $clog2(WINDOW_CELLS + 1);
  localparam int IW   = $clog2(WINDOW_CELLS);
  localparam int PW   = $clog2(WINDOW_CELLS + 2 * MAP_DIM);
  localparam int XW   = $clog2(MAP_DIM);
  localparam int NXW  = XW + 2;
  localparam int RW   = NXW + 1;
  localparam int SW   = $clog2(SPAN * SPAN + WINDOW_CELLS + 1);
  localparam logic [NW-1:0] ROOT = NW'(POOL - 1);
  localparam logic signed [RW-1:0] SPAN_S = RW'(SPAN);
  localparam logic signed [RW-1:0] RAD_S  = RW'(RADIUS);

  typedef struct packed {
    logic [XW-1:0] x;
    logic [XW-1:0] y;
    logic [CW-1:0] cost;
    logic [NW-1:0] parent;
    logic          has_par;
  } node_t;

  typedef struct packed {
    logic [NW-1:0] node;
    logic [PW-1:0] prio;
  } oent_t;

  function automatic logic [NXW-1:0] absd(input logic signed [NXW-1:0] v);
    return v[NXW-1] ? NXW'(-v) : NXW'(v);
  endfunction

  // memories
  logic [MAP_DIM-1:0] map_mem [MAP_DIM];
  logic [MAP_DIM-1:0] row_vld;
  logic [CW-1:0]      best_mem [WINDOW_CELLS];
  node_t              node_mem [POOL];
  oent_t              open_mem [2**NW];

  // request and configuration
  logic          req_find, cwalk;
  logic [XW-1:0] cx, cy, sx, sy, gx, gy;
  logic [CFG_W-1:0] map_w, map_h;

  // read data
  logic [MAP_DIM-1:0] map_rd;
  logic               map_rdv;
  logic [CW-1:0]      best_rd;
  node_t              node_rd;
  oent_t              open_rd;

  // search state
  logic [IW-1:0]  clr_cnt;
  logic [OCW-1:0] ocount, ins_i;
  logic [NW-1:0]  head, cur_id, cur_par, chain_ptr;
  logic [CW-1:0]  ecnt, cur_cost;
  logic [XW-1:0]  cur_x, cur_y;
  logic           cur_has;
  logic [2:0]     k;
  logic signed [NXW-1:0] nb_x, nb_y;
  logic           nb_geo;
  logic [IW-1:0]  nb_idx;
  logic [PW-1:0]  nb_prio;
  logic           res_found;
  logic [XW-1:0]  res_x, res_y;

  // neighbour geometry
  logic signed [NXW-1:0] nx_c, ny_c, dx_c, dy_c;
  logic signed [RW-1:0]  rx_c, ry_c;
  logic [SW-1:0]         idx_c;
  logic                  in_map, in_win, idx_ok;
  logic [CW-1:0]         ncost;
  logic [PW-1:0]         prio_c, h0;
  logic [NW-1:0]         slot;
  oent_t                 new_ent;

  always_comb begin
    nx_c   = $signed({2'b00, cur_x}) + NXW'(dir_dx(k));
    ny_c   = $signed({2'b00, cur_y}) + NXW'(dir_dy(k));
    dx_c   = nx_c - $signed({2'b00, gx});
    dy_c   = ny_c - $signed({2'b00, gy});
    rx_c   = {dx_c[NXW-1], dx_c} + RAD_S;
    ry_c   = {dy_c[NXW-1], dy_c} + RAD_S;
    in_map = !nx_c[NXW-1] && !ny_c[NXW-1]
          && ($unsigned(nx_c) < NXW'(map_w)) && ($unsigned(ny_c) < NXW'(map_h))
          && ($unsigned(nx_c) < NXW'(MAP_DIM)) && ($unsigned(ny_c) < NXW'(MAP_DIM));
    in_win = !rx_c[RW-1] && !ry_c[RW-1] && (rx_c < SPAN_S) && (ry_c < SPAN_S);
    idx_c  = SW'($unsigned(ry_c[RW-2:0])) * SW'(SPAN) + SW'($unsigned(rx_c[RW-2:0]));
    idx_ok = idx_c < SW'(WINDOW_CELLS);
    ncost  = cur_cost + CW'(1);
    prio_c = PW'(ncost) + PW'(absd(dx_c)) + PW'(absd(dy_c));
    h0     = PW'(absd($signed({2'b00, sx}) - $signed({2'b00, gx})))
           + PW'(absd($signed({2'b00, sy}) - $signed({2'b00, gy})));
    slot   = NW'({ecnt, k});
    new_ent.node = slot;
    new_ent.prio = nb_prio;
  end

  always_comb begin
    stat.is_find     = req_find;
    stat.clr_last    = (clr_cnt == IW'(WINDOW_CELLS - 1));
    stat.pop_stop    = (ecnt == CW'(WINDOW_CELLS)) || (ocount == '0);
    stat.at_goal     = (cur_x == gx) && (cur_y == gy);
    stat.nb_pass     = nb_geo && map_rdv && map_rd[nb_x[XW-1:0]] && (ncost < best_rd);
    stat.chain_hit   = (node_rd.x == nb_x[XW-1:0]) && (node_rd.y == nb_y[XW-1:0]);
    stat.chain_root  = !node_rd.has_par;
    stat.ins_direct  = (ocount >= OCW'(POOL)) || (ocount == '0);
    stat.ins_shift   = open_rd.prio > nb_prio;
    stat.ins_first   = (ins_i == '0);
    stat.k_last      = (k == 3'd7);
    stat.cur_has_par = cur_has;
    stat.trace_root  = !node_rd.has_par;
    stat.out_free    = !out_valid || !out_stall;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      map_w <= CFG_W'(MAP_DIM);
      map_h <= CFG_W'(MAP_DIM);
    end else if (cfg_write) begin
      if (cfg_index == REG_MAP_WIDTH)  map_w <= cfg_data;
      if (cfg_index == REG_MAP_HEIGHT) map_h <= cfg_data;
    end
  end

  // walk map: one row per entry, read-modify-write for a cell
  always_ff @(posedge clk) begin
    if (cmd.op == OP_MAP_RD) begin
      map_rd <= map_mem[cy];
    end else if (cmd.op == OP_NB_RD) begin
      map_rd <= map_mem[ny_c[XW-1:0]];
    end
    if (cmd.op == OP_MAP_WR) begin
      map_mem[cy] <= (map_rdv ? map_rd : '0) & ~(MAP_DIM'(1) << cx)
                   | (MAP_DIM'(cwalk) << cx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld <= '0;
      map_rdv <= 1'b0;
    end else begin
      if (cmd.op == OP_MAP_RD) map_rdv <= row_vld[cy];
      else if (cmd.op == OP_NB_RD) map_rdv <= row_vld[ny_c[XW-1:0]];
      if (cmd.op == OP_MAP_WR) row_vld[cy] <= 1'b1;
    end
  end

  // best-cost store
  always_ff @(posedge clk) begin
    if (cmd.op == OP_CLR) best_mem[clr_cnt] <= CW'(WINDOW_CELLS);
    else if (cmd.op == OP_ADD) best_mem[nb_idx] <= ncost;
    if (cmd.op == OP_NB_RD && in_map && in_win && idx_ok) best_rd <= best_mem[idx_c[IW-1:0]];
  end

  // node pool
  always_ff @(posedge clk) begin
    if (cmd.op == OP_INIT) begin
      node_mem[ROOT] <= '{x: sx, y: sy, cost: '0, parent: '0, has_par: 1'b0};
    end else if (cmd.op == OP_ADD) begin
      node_mem[slot] <= '{x: nb_x[XW-1:0], y: nb_y[XW-1:0], cost: ncost,
                          parent: cur_id, has_par: 1'b1};
    end
    case (cmd.op)
      OP_POP_W:    node_rd <= node_mem[open_rd.node];
      OP_CHAIN_RD: node_rd <= node_mem[chain_ptr];
      OP_TRACE:    node_rd <= node_mem[cur_par];
      OP_TRACE_W:  if (node_rd.has_par) node_rd <= node_mem[node_rd.parent];
      default: ;
    endcase
  end

  // open list: circular, sorted from head; insert shifts the tail up
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_INIT: open_mem[head] <= '{node: ROOT, prio: h0};
      OP_ADD: begin
        if (ocount == '0) open_mem[head] <= new_ent;
        else if (ocount < OCW'(POOL)) open_rd <= open_mem[head + NW'(ocount - OCW'(1))];
      end
      OP_INS: begin
        if (stat.ins_shift) begin
          open_mem[head + NW'(ins_i) + NW'(1)] <= open_rd;
          if (!stat.ins_first) open_rd <= open_mem[head + NW'(ins_i - OCW'(1))];
        end else begin
          open_mem[head + NW'(ins_i) + NW'(1)] <= new_ent;
        end
      end
      OP_INS_HEAD: open_mem[head] <= new_ent;
      OP_POP: if (!stat.pop_stop) open_rd <= open_mem[head];
      default: ;
    endcase
  end

  // search control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      req_find <= 1'b0;
      clr_cnt  <= '0;
      ocount   <= '0;
      head     <= '0;
      ecnt     <= '0;
      ins_i    <= '0;
      k        <= '0;
    end else begin
      case (cmd.op)
        OP_CAPTURE: begin
          req_find <= operation;
          clr_cnt  <= '0;
          ocount   <= '0;
          head     <= '0;
          ecnt     <= '0;
        end
        OP_CLR:  clr_cnt <= clr_cnt + IW'(1);
        OP_INIT: ocount <= OCW'(1);
        OP_POP: begin
          if (!stat.pop_stop) begin
            head   <= head + NW'(1);
            ocount <= ocount - OCW'(1);
          end
        end
        OP_NODE_W: k <= '0;
        OP_ADD: begin
          if (ocount == '0) ocount <= OCW'(1);
          else if (ocount < OCW'(POOL)) ins_i <= ocount - OCW'(1);
        end
        OP_INS: begin
          if (!stat.ins_shift) ocount <= ocount + OCW'(1);
          else if (!stat.ins_first) ins_i <= ins_i - OCW'(1);
        end
        OP_INS_HEAD: ocount <= ocount + OCW'(1);
        OP_NB_NEXT: begin
          if (stat.k_last) ecnt <= ecnt + CW'(1);
          else             k <= k + 3'd1;
        end
        default: ;
      endcase
    end
  end

  // request fields, current node and neighbour registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CAPTURE: begin
        cx    <= cell_x;
        cy    <= cell_y;
        cwalk <= cell_walkable;
        sx    <= start_x;
        sy    <= start_y;
        gx    <= goal_x;
        gy    <= goal_y;
      end
      OP_INIT: begin
        cur_x <= sx;
        cur_y <= sy;
      end
      OP_POP_W: cur_id <= open_rd.node;
      OP_NODE_W: begin
        cur_x    <= node_rd.x;
        cur_y    <= node_rd.y;
        cur_cost <= node_rd.cost;
        cur_par  <= node_rd.parent;
        cur_has  <= node_rd.has_par;
      end
      OP_NB_RD: begin
        nb_x    <= nx_c;
        nb_y    <= ny_c;
        nb_geo  <= in_map && in_win && idx_ok;
        nb_idx  <= idx_c[IW-1:0];
        nb_prio <= prio_c;
      end
      OP_NB_CHK: chain_ptr <= cur_id;
      OP_CHAIN_CK: chain_ptr <= node_rd.parent;
      OP_TRACE_W: begin
        // the node whose parent is the root is the first move
        if (!node_rd.has_par) begin
          res_found <= 1'b1;
          res_x     <= cur_x;
          res_y     <= cur_y;
        end else begin
          cur_x <= node_rd.x;
          cur_y <= node_rd.y;
        end
      end
      OP_FAIL: begin
        res_found <= 1'b0;
        res_x     <= '0;
        res_y     <= '0;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_LOAD && stat.out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD && stat.out_free) begin
      found  <= res_found;
      step_x <= res_x;
      step_y <= res_y;
    end
  end

endmodule

### hw/rtl/gast_chk.sv
// ----------------------------------------------------------------------------
// gast_chk
// Port-level checks for the grid A* next-step finder.
// ----------------------------------------------------------------------------
module gast_chk (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       found,
  input logic [5:0] step_x,
  input logic [5:0] step_y
);

  // a pending result must not be withdrawn
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // an accepted transaction makes the block busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while block should be busy");

  // a miss carries a zero step
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> step_x == 6'd0 && step_y == 6'd0)
    else $error("not-found result with non-zero step");

  // a result appears only at the end of a search
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a search");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind grid_astar_next_step gast_chk u_gast_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .found     (found),
  .step_x    (step_x),
  .step_y    (step_y)
);
